@@ design/dg_p2_zone_update_macros.svh @@
// assertion macros for the dg p2 zone update block
`ifndef DG_P2_ZONE_UPDATE_MACROS_SVH
`define DG_P2_ZONE_UPDATE_MACROS_SVH

// check gated off while reset is high
`define DGP2_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that also holds across reset
`define DGP2_ASSERT_RST(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/dgp2_pkg.sv @@
// types, constants and rounding helpers for the dg p2 zone update block
`default_nettype none
package dgp2_pkg;

   // accumulator width for sums of three 64-bit products plus rounding
   localparam int ACC_W = 68;
   localparam int KQ    = 28;
   localparam int RKQ   = 16;
   localparam logic [16:0] RK_ONE = 17'd65536;

   // configuration register indexes
   localparam logic [2:0] CSR_PDE_MODE   = 3'd0;
   localparam logic [2:0] CSR_WAVE_SPEED = 3'd1;
   localparam logic [2:0] CSR_INV_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_TIME_STEP  = 3'd3;
   localparam logic [2:0] CSR_RK_WEIGHT  = 3'd4;

   // equation codes
   localparam logic MODE_LINEAR  = 1'b0;
   localparam logic MODE_BURGERS = 1'b1;

   // basis tables, signed Q3.28
   localparam logic signed [31:0] FACE_LO [3] = '{32'sd268435456, -32'sd464943848,
                                                 32'sd600239927};
   localparam logic signed [31:0] FACE_HI [3] = '{32'sd268435456, 32'sd464943848,
                                                 32'sd600239927};
   // legendre value at gauss point, [order][point]
   localparam logic signed [31:0] LEG_AT [3][3] = '{
      '{32'sd268435456, 32'sd268435456, 32'sd268435456},
      '{-32'sd360143956, 32'sd0, 32'sd360143956},
      '{32'sd240095971, -32'sd300119964, 32'sd240095971}};
   // legendre derivative at gauss point, [order][point]
   localparam logic signed [31:0] DLEG_AT [3][3] = '{
      '{32'sd0, 32'sd0, 32'sd0},
      '{32'sd464943848, 32'sd464943848, 32'sd464943848},
      '{-32'sd1394831545, 32'sd0, 32'sd1394831545}};
   localparam logic signed [31:0] GAUSS_W [3] = '{32'sd149130809, 32'sd238609294,
                                                 32'sd149130809};

   // clipped 32-bit value with its clip flag
   typedef struct packed {
      logic               sat;
      logic signed [31:0] val;
   } sat32_type;

   // zone data carried down the pipe
   typedef struct packed {
      logic [2:0][31:0] ctr;
      logic [2:0][31:0] base;
      logic             sat;
   } carry_type;

   // saturate to signed 32 bits
   function automatic sat32_type clip32(input logic signed [ACC_W-1:0] x);
      sat32_type r;
      r.sat = !((&x[ACC_W-1:31]) || !(|x[ACC_W-1:31]));
      if (r.sat) begin
         r.val = x[ACC_W-1] ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
         r.val = x[31:0];
      end
      return r;
   endfunction

   // round half up by sh bits, then saturate
   function automatic sat32_type rnd_sat(input logic signed [ACC_W-1:0] x,
                                         input int unsigned sh);
      logic signed [ACC_W-1:0] half;
      logic signed [ACC_W-1:0] y;
      half = '0;
      half[sh-1] = 1'b1;
      y = (x + half) >>> sh;
      return clip32(y);
   endfunction

endpackage
`default_nettype wire

@@ design/dgp2_req_if.sv @@
// request channel carrying one zone stencil word
`default_nettype none
interface dgp2_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] left_coef0;
   logic signed [31:0] left_coef1;
   logic signed [31:0] left_coef2;
   logic signed [31:0] center_coef0;
   logic signed [31:0] center_coef1;
   logic signed [31:0] center_coef2;
   logic signed [31:0] right_coef0;
   logic signed [31:0] right_coef1;
   logic signed [31:0] right_coef2;
   logic signed [31:0] base_coef0;
   logic signed [31:0] base_coef1;
   logic signed [31:0] base_coef2;

   modport source (output valid, left_coef0, left_coef1, left_coef2, center_coef0,
                   center_coef1, center_coef2, right_coef0, right_coef1, right_coef2,
                   base_coef0, base_coef1, base_coef2, input ready);
   modport sink (input valid, left_coef0, left_coef1, left_coef2, center_coef0,
                 center_coef1, center_coef2, right_coef0, right_coef1, right_coef2,
                 base_coef0, base_coef1, base_coef2, output ready);
endinterface
`default_nettype wire

@@ design/dgp2_rsp_if.sv @@
// response channel carrying one updated zone word
`default_nettype none
interface dgp2_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] new_coef0;
   logic signed [31:0] new_coef1;
   logic signed [31:0] new_coef2;
   logic               saturated;

   modport source (output valid, new_coef0, new_coef1, new_coef2, saturated,
                   input ready);
   modport sink (input valid, new_coef0, new_coef1, new_coef2, saturated,
                 output ready);
endinterface
`default_nettype wire

@@ design/dg_p2_zone_update.sv @@
// an accepted request word moves through pipeline stages 0 to 14 to become its response word
// throughput: one word per cycle while the response is not stalled, set by the 15-stage pipeline advancing as one
// a stalled response freezes the whole pipe; nothing is dropped or repeated
// reset (synchronous, active high) empties the pipe and loads register defaults
`default_nettype none
`include "dg_p2_zone_update_macros.svh"
module dg_p2_zone_update
   import dgp2_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   dgp2_req_if.sink         req,
   dgp2_rsp_if.source       rsp,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int NSTG = 15;

   // configuration registers
   logic               pde_mode_ff;
   logic signed [31:0] wave_speed_ff;
   logic [30:0]        icw_ff;
   logic [30:0]        ts_ff;
   logic [16:0]        rk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pde_mode_ff   <= MODE_LINEAR;
         wave_speed_ff <= 32'sd65536;
         icw_ff        <= 31'd65536;
         ts_ff         <= 31'd655;
         rk_ff         <= 17'd0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PDE_MODE:   pde_mode_ff   <= csr_wdata[0];
            CSR_WAVE_SPEED: wave_speed_ff <= csr_wdata;
            CSR_INV_WIDTH:  icw_ff        <= csr_wdata[30:0];
            CSR_TIME_STEP:  ts_ff         <= csr_wdata[30:0];
            CSR_RK_WEIGHT:  rk_ff <= (csr_wdata[16:0] > RK_ONE) ? RK_ONE : csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   // pipe control
   logic [NSTG-1:0] vld_ff;
   logic            adv_en;

   assign adv_en    = !vld_ff[NSTG-1] || rsp.ready;
   assign req.ready = adv_en;
   assign rsp.valid = vld_ff[NSTG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv_en) begin
         vld_ff <= {vld_ff[NSTG-2:0], req.valid};
      end
   end

   // stage registers
   carry_type          car_ff [NSTG-1];
   carry_type          car_in [NSTG-1];
   logic signed [31:0] lft0_ff [3];
   logic signed [31:0] rgt0_ff [3];
   logic signed [63:0] fp1_ff [4][3];
   logic signed [63:0] fp1_in [4][3];
   logic signed [63:0] up1_ff [3][3];
   logic signed [63:0] up1_in [3][3];
   logic signed [31:0] fv2_ff [4];
   logic signed [31:0] fv2_in [4];
   logic signed [31:0] u2_ff [3];
   logic signed [31:0] u2_in [3];
   logic signed [63:0] ffp3_ff [2];
   logic signed [63:0] ffp3_in [2];
   logic               fz3_ff [2];
   logic               fz3_in [2];
   logic signed [63:0] pfp3_ff [3];
   logic signed [63:0] pfp3_in [3];
   logic signed [31:0] fl4_ff [2];
   logic signed [31:0] fl4_in [2];
   logic signed [31:0] pf4_ff [3];
   logic signed [31:0] pf4_in [3];
   logic signed [63:0] wp5_ff [3];
   logic signed [63:0] wp5_in [3];
   logic signed [63:0] slo5_ff [3];
   logic signed [63:0] slo5_in [3];
   logic signed [63:0] shi5_ff [3];
   logic signed [63:0] shi5_in [3];
   logic signed [31:0] wfx6_ff [3];
   logic signed [31:0] wfx6_in [3];
   logic signed [31:0] surf6_ff [3];
   logic signed [31:0] surf6_in [3];
   logic signed [63:0] vp7_ff [3][3];
   logic signed [63:0] vp7_in [3][3];
   logic signed [31:0] surf7_ff [3];
   logic signed [31:0] rate8_ff [3];
   logic signed [31:0] rate8_in [3];
   logic signed [63:0] rp9_ff [3];
   logic signed [63:0] rp9_in [3];
   logic signed [31:0] sc10_ff [3];
   logic signed [31:0] sc10_in [3];
   logic signed [63:0] ip11_ff [3];
   logic signed [63:0] ip11_in [3];
   logic signed [31:0] adv12_ff [3];
   logic signed [31:0] adv12_in [3];
   logic signed [63:0] bla13_ff [3];
   logic signed [63:0] bla13_in [3];
   logic signed [63:0] blb13_ff [3];
   logic signed [63:0] blb13_in [3];
   logic signed [31:0] out14_ff [3];
   logic signed [31:0] out14_in [3];
   logic               osat14_ff;
   logic               osat14_in;

   // datapath for all stages
   always_comb begin
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] acc_b;
      logic signed [31:0]      fa;
      logic signed [31:0]      fb;
      logic signed [31:0]      op;
      logic signed [31:0]      mul;
      logic                    s;
      sat32_type               r;
      sat32_type               r2;
      logic signed [17:0]      rk_s;
      logic signed [17:0]      rk_c;

      // stage 0: capture request word
      car_in[0].ctr  = {req.center_coef2, req.center_coef1, req.center_coef0};
      car_in[0].base = {req.base_coef2, req.base_coef1, req.base_coef0};
      car_in[0].sat  = 1'b0;
      for (int k = 1; k < NSTG-1; k++) begin
         car_in[k] = car_ff[k-1];
      end

      // stage 1: face and gauss point products
      for (int l = 0; l < 3; l++) begin
         fp1_in[0][l] = lft0_ff[l] * FACE_HI[l];
         fp1_in[1][l] = $signed(car_ff[0].ctr[l]) * FACE_LO[l];
         fp1_in[2][l] = $signed(car_ff[0].ctr[l]) * FACE_HI[l];
         fp1_in[3][l] = rgt0_ff[l] * FACE_LO[l];
         for (int n = 0; n < 3; n++) begin
            up1_in[n][l] = $signed(car_ff[0].ctr[l]) * LEG_AT[l][n];
         end
      end

      // stage 2: face and point values
      s = 1'b0;
      for (int f = 0; f < 4; f++) begin
         acc = ACC_W'(fp1_ff[f][0]);
         acc = acc + ACC_W'(fp1_ff[f][1]);
         acc = acc + ACC_W'(fp1_ff[f][2]);
         r = rnd_sat(acc, KQ);
         fv2_in[f] = r.val;
         s = s | r.sat;
      end
      for (int n = 0; n < 3; n++) begin
         acc = ACC_W'(up1_ff[n][0]);
         acc = acc + ACC_W'(up1_ff[n][1]);
         acc = acc + ACC_W'(up1_ff[n][2]);
         r = rnd_sat(acc, KQ);
         u2_in[n] = r.val;
         s = s | r.sat;
      end
      car_in[2].sat = car_ff[1].sat | s;

      // stage 3: upwind choice and flux products
      for (int f = 0; f < 2; f++) begin
         fa = fv2_ff[2*f];
         fb = fv2_ff[2*f+1];
         fz3_in[f] = 1'b0;
         if (pde_mode_ff == MODE_LINEAR) begin
            op = (wave_speed_ff > 0) ? fa : fb;
            mul = wave_speed_ff;
         end else begin
            if (fa > 0 && fb > 0) begin
               op = fa;
            end else if (fa < 0 && fb < 0) begin
               op = fb;
            end else begin
               op = fb;
               fz3_in[f] = 1'b1;
            end
            mul = op;
         end
         ffp3_in[f] = op * mul;
      end
      for (int n = 0; n < 3; n++) begin
         mul = (pde_mode_ff == MODE_LINEAR) ? wave_speed_ff : u2_ff[n];
         pfp3_in[n] = u2_ff[n] * mul;
      end

      // stage 4: flux rounding
      s = 1'b0;
      for (int f = 0; f < 2; f++) begin
         acc = ACC_W'(ffp3_ff[f]);
         r = rnd_sat(acc, (pde_mode_ff == MODE_LINEAR) ? FRAC_BITS : FRAC_BITS + 1);
         fl4_in[f] = fz3_ff[f] ? 32'sd0 : r.val;
         s = s | (r.sat & !fz3_ff[f]);
      end
      for (int n = 0; n < 3; n++) begin
         acc = ACC_W'(pfp3_ff[n]);
         r = rnd_sat(acc, (pde_mode_ff == MODE_LINEAR) ? FRAC_BITS : FRAC_BITS + 1);
         pf4_in[n] = r.val;
         s = s | r.sat;
      end
      car_in[4].sat = car_ff[3].sat | s;

      // stage 5: gauss weight and surface products
      for (int i = 0; i < 3; i++) begin
         wp5_in[i]  = pf4_ff[i] * GAUSS_W[i];
         slo5_in[i] = fl4_ff[0] * FACE_LO[i];
         shi5_in[i] = fl4_ff[1] * FACE_HI[i];
      end

      // stage 6: weighted point flux and surface term
      s = 1'b0;
      for (int i = 0; i < 3; i++) begin
         acc = ACC_W'(wp5_ff[i]);
         r = rnd_sat(acc, KQ);
         wfx6_in[i] = r.val;
         acc = ACC_W'(slo5_ff[i]);
         acc_b = ACC_W'(shi5_ff[i]);
         r2 = rnd_sat(acc - acc_b, KQ);
         surf6_in[i] = r2.val;
         s = s | r.sat | r2.sat;
      end
      car_in[6].sat = car_ff[5].sat | s;

      // stage 7: volume products
      for (int i = 0; i < 3; i++) begin
         for (int n = 0; n < 3; n++) begin
            vp7_in[i][n] = wfx6_ff[n] * DLEG_AT[i][n];
         end
      end

      // stage 8: volume term plus surface term
      s = 1'b0;
      for (int i = 0; i < 3; i++) begin
         acc = ACC_W'(vp7_ff[i][0]);
         acc = acc + ACC_W'(vp7_ff[i][1]);
         acc = acc + ACC_W'(vp7_ff[i][2]);
         r = rnd_sat(acc, KQ);
         acc = ACC_W'(r.val);
         acc_b = ACC_W'(surf7_ff[i]);
         r2 = clip32(acc + acc_b);
         rate8_in[i] = r2.val;
         s = s | r.sat | r2.sat;
      end
      car_in[8].sat = car_ff[7].sat | s;

      // stage 9: scale by inverse width
      for (int i = 0; i < 3; i++) begin
         rp9_in[i] = rate8_ff[i] * $signed({1'b0, icw_ff});
      end

      // stage 10: round scaled rate
      s = 1'b0;
      for (int i = 0; i < 3; i++) begin
         acc = ACC_W'(rp9_ff[i]);
         r = rnd_sat(acc, FRAC_BITS);
         sc10_in[i] = r.val;
         s = s | r.sat;
      end
      car_in[10].sat = car_ff[9].sat | s;

      // stage 11: scale by time step
      for (int i = 0; i < 3; i++) begin
         ip11_in[i] = sc10_ff[i] * $signed({1'b0, ts_ff});
      end

      // stage 12: increment and advance
      s = 1'b0;
      for (int i = 0; i < 3; i++) begin
         acc = ACC_W'(ip11_ff[i]);
         r = rnd_sat(acc, FRAC_BITS);
         acc = ACC_W'(r.val);
         acc_b = ACC_W'($signed(car_ff[11].ctr[i]));
         r2 = clip32(acc + acc_b);
         adv12_in[i] = r2.val;
         s = s | r.sat | r2.sat;
      end
      car_in[12].sat = car_ff[11].sat | s;

      // stage 13: blend products
      rk_s = $signed({1'b0, rk_ff});
      rk_c = $signed({1'b0, RK_ONE}) - rk_s;
      for (int i = 0; i < 3; i++) begin
         bla13_in[i] = rk_c * adv12_ff[i];
         blb13_in[i] = rk_s * $signed(car_ff[12].base[i]);
      end

      // stage 14: blend sum into the response word
      s = 1'b0;
      for (int i = 0; i < 3; i++) begin
         acc = ACC_W'(bla13_ff[i]);
         acc_b = ACC_W'(blb13_ff[i]);
         r = rnd_sat(acc + acc_b, RKQ);
         out14_in[i] = r.val;
         s = s | r.sat;
      end
      osat14_in = car_ff[13].sat | s;
   end

   // stage payload registers
   always_ff @(posedge clock) begin
      if (adv_en) begin
         for (int k = 0; k < NSTG-1; k++) begin
            car_ff[k] <= car_in[k];
         end
         lft0_ff  <= '{req.left_coef0, req.left_coef1, req.left_coef2};
         rgt0_ff  <= '{req.right_coef0, req.right_coef1, req.right_coef2};
         fp1_ff   <= fp1_in;
         up1_ff   <= up1_in;
         fv2_ff   <= fv2_in;
         u2_ff    <= u2_in;
         ffp3_ff  <= ffp3_in;
         fz3_ff   <= fz3_in;
         pfp3_ff  <= pfp3_in;
         fl4_ff   <= fl4_in;
         pf4_ff   <= pf4_in;
         wp5_ff   <= wp5_in;
         slo5_ff  <= slo5_in;
         shi5_ff  <= shi5_in;
         wfx6_ff  <= wfx6_in;
         surf6_ff <= surf6_in;
         vp7_ff   <= vp7_in;
         surf7_ff <= surf6_ff;
         rate8_ff <= rate8_in;
         rp9_ff   <= rp9_in;
         sc10_ff  <= sc10_in;
         ip11_ff  <= ip11_in;
         adv12_ff <= adv12_in;
         bla13_ff <= bla13_in;
         blb13_ff <= blb13_in;
         out14_ff <= out14_in;
         osat14_ff <= osat14_in;
      end
   end

   // response word
   assign rsp.new_coef0 = out14_ff[0];
   assign rsp.new_coef1 = out14_ff[1];
   assign rsp.new_coef2 = out14_ff[2];
   assign rsp.saturated = osat14_ff;

   // checks
   `DGP2_ASSERT_RST(a_reset_empty, reset |=> vld_ff == '0, "pipe not empty after reset")
   `DGP2_ASSERT(a_stall_freeze, !adv_en |=> vld_ff == $past(vld_ff), "valid bits moved in stall")
   `DGP2_ASSERT(a_enter, req.valid && adv_en |=> vld_ff[0], "accepted word not in first stage")

endmodule
`default_nettype wire
